// ===== hw/rtl/ntid_pkg.sv =====
`timescale 1ns / 1ps

package ntid_pkg;

   // operation selector carried with every character
   typedef enum logic [1:0] {
      MODE_CREATE,
      MODE_DELETE,
      MODE_SEARCH,
      MODE_NONE
   } mode_type;

   // result status codes
   typedef enum logic [2:0] {
      ST_CREATED,
      ST_FULL,
      ST_EXISTS,
      ST_DELETED,
      ST_NOTFOUND,
      ST_FOUND,
      ST_TOOLONG
   } status_type;

   // back end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CHAR,
      BK_CHAR_CMP,
      BK_FIND,
      BK_FIND_CMP,
      BK_CREATE,
      BK_COPY,
      BK_RESULT
   } back_state_type;

endpackage

// ===== hw/rtl/ntid_ram.sv =====
`timescale 1ns / 1ps

module ntid_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hw/rtl/ntid_front.sv =====
`timescale 1ns / 1ps

module ntid_front import ntid_pkg::*; #(
   parameter int NAME_BYTES = 32,
   localparam int PW = $clog2(NAME_BYTES),
   localparam int CMD_W = 2 * PW + 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       name_char,
   input  logic [1:0]       req_mode,
   input  logic             name_last,
   input  logic             q_full,
   output logic             q_push,
   output logic [CMD_W-1:0] q_data
);

   typedef struct packed {
      logic           has_char;
      logic [7:0]     ch;
      logic [PW-1:0]  pos;
      logic [PW-1:0]  end_pos;
      logic           last;
      mode_type       mode;
      logic           too_long;
   } cmd_type;

   logic [PW-1:0] pos_ff, pos_in;
   logic          toolong_ff, toolong_in;
   logic          accept;
   logic          has_char;
   logic          at_limit;
   logic          take;
   cmd_type       cmd;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign has_char   = (name_char != 8'h00);
   assign at_limit   = (pos_ff == PW'(NAME_BYTES - 1));
   assign take       = has_char && !at_limit;

   always_comb begin
      cmd.has_char = take;
      cmd.ch       = name_char;
      cmd.pos      = pos_ff;
      cmd.end_pos  = take ? pos_ff + PW'(1) : pos_ff;
      cmd.last     = name_last;
      cmd.mode     = mode_type'(req_mode);
      cmd.too_long = toolong_ff || (has_char && at_limit);
   end

   assign q_push = accept && (take || name_last);
   assign q_data = cmd;

   always_comb begin
      pos_in     = pos_ff;
      toolong_in = toolong_ff;
      if (accept) begin
         if (name_last) begin
            pos_in     = '0;
            toolong_in = 1'b0;
         end else if (take) begin
            pos_in = pos_ff + PW'(1);
         end else if (has_char) begin
            toolong_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         toolong_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         toolong_ff <= toolong_in;
      end
   end

endmodule

// ===== hw/rtl/ntid_fifo.sv =====
`timescale 1ns / 1ps

module ntid_fifo #(
   parameter int WIDTH = 23,
   parameter int DEPTH = 4,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int FW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] head
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full      = (fill_ff == FW'(DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/ntid_back.sv =====
`timescale 1ns / 1ps

module ntid_back import ntid_pkg::*; #(
   parameter int MAX_ENTRIES = 16,
   parameter int NAME_BYTES = 32,
   localparam int PW = $clog2(NAME_BYTES),
   localparam int CW = $clog2(MAX_ENTRIES + 1),
   localparam int CMD_W = 2 * PW + 13
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  logic [CMD_W-1:0] cmd_head,
   output logic             cmd_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output status_type       rsp_status,
   output logic [CW-1:0]    rsp_count
);

   localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SW = $clog2(NAME_BYTES + 1);

   typedef struct packed {
      logic           has_char;
      logic [7:0]     ch;
      logic [PW-1:0]  pos;
      logic [PW-1:0]  end_pos;
      logic           last;
      mode_type       mode;
      logic           too_long;
   } cmd_type;

   back_state_type         state_ff, state_in;
   cmd_type                cmd_ff, cmd_in;
   cmd_type                head;
   logic [CW-1:0]          count_ff, count_in;
   logic [MAX_ENTRIES-1:0] flags_ff, flags_in;
   logic [EW-1:0]          hit_idx_ff, hit_idx_in;
   logic [SW-1:0]          sweep_ff, sweep_in;
   status_type             status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [CW-1:0]          rsp_count_ff, rsp_count_in;

   // lane memories, one per table entry, all read at the same position
   logic [7:0]             lane_rd_data [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] lane_wr_en;
   logic [PW-1:0]          lane_rd_addr;
   logic [PW-1:0]          lane_wr_addr;
   logic [7:0]             lane_wr_data;
   logic                   inc_wr_en;
   logic [7:0]             inc_rd_data;
   logic [PW-1:0]          inc_rd_addr;

   logic [MAX_ENTRIES-1:0] match_vec;
   logic                   hit_any;
   logic [EW-1:0]          hit_idx;
   logic                   full;
   logic [CW-1:0]          count_dec;
   logic [EW-1:0]          last_idx;
   logic                   sweep_done;
   logic                   wr_go;
   logic [EW-1:0]          wr_lane;
   logic [PW-1:0]          sweep_prev;
   logic                   out_free;

   assign head       = cmd_head;
   assign full       = (count_ff == CW'(MAX_ENTRIES));
   assign count_dec  = count_ff - CW'(1);
   assign last_idx   = count_dec[EW-1:0];
   assign sweep_done = (sweep_ff == SW'(NAME_BYTES));
   assign sweep_prev = PW'(sweep_ff - SW'(1));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   generate
      for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_lane
         ntid_ram #(
            .WIDTH (8),
            .DEPTH (NAME_BYTES)
         ) u_lane (
            .clock   (clock),
            .wr_en   (lane_wr_en[g]),
            .wr_addr (lane_wr_addr),
            .wr_data (lane_wr_data),
            .rd_addr (lane_rd_addr),
            .rd_data (lane_rd_data[g])
         );
      end
   endgenerate

   ntid_ram #(
      .WIDTH (8),
      .DEPTH (NAME_BYTES)
   ) u_incoming (
      .clock   (clock),
      .wr_en   (inc_wr_en),
      .wr_addr (cmd_ff.pos),
      .wr_data (cmd_ff.ch),
      .rd_addr (inc_rd_addr),
      .rd_data (inc_rd_data)
   );

   // held entries that still match and end at the name's end
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         match_vec[i] = flags_ff[i] && (lane_rd_data[i] == 8'h00) &&
                        (CW'(i) < count_ff);
      end
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            hit_idx = EW'(i);
         end
      end
   end

   assign hit_any = |match_vec;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (head.has_char) begin
                  state_in = BK_CHAR;
               end else if (head.last) begin
                  state_in = BK_FIND;
               end
            end
         end
         BK_CHAR:     state_in = BK_CHAR_CMP;
         BK_CHAR_CMP: state_in = cmd_ff.last ? BK_FIND : BK_IDLE;
         BK_FIND:     state_in = BK_FIND_CMP;
         BK_FIND_CMP: begin
            if (cmd_ff.mode == MODE_NONE) begin
               state_in = BK_IDLE;
            end else if (cmd_ff.too_long) begin
               state_in = BK_RESULT;
            end else begin
               unique case (cmd_ff.mode)
                  MODE_CREATE: state_in = (full || hit_any) ? BK_RESULT : BK_CREATE;
                  MODE_DELETE: begin
                     state_in = (hit_any && hit_idx != last_idx) ? BK_COPY : BK_RESULT;
                  end
                  default:     state_in = BK_RESULT;
               endcase
            end
         end
         BK_CREATE:   state_in = sweep_done ? BK_RESULT : BK_CREATE;
         BK_COPY:     state_in = sweep_done ? BK_RESULT : BK_COPY;
         BK_RESULT:   state_in = out_free ? BK_IDLE : BK_RESULT;
         default:     state_in = BK_IDLE;
      endcase
   end

   // memory controls
   always_comb begin
      cmd_pop      = 1'b0;
      inc_wr_en    = 1'b0;
      lane_rd_addr = sweep_ff[PW-1:0];
      inc_rd_addr  = sweep_ff[PW-1:0];
      lane_wr_addr = sweep_prev;
      wr_go        = 1'b0;
      wr_lane      = hit_idx_ff;
      lane_wr_data = lane_rd_data[last_idx];
      unique case (state_ff)
         BK_IDLE: cmd_pop = cmd_valid;
         BK_CHAR: begin
            inc_wr_en    = 1'b1;
            lane_rd_addr = cmd_ff.pos;
         end
         BK_FIND: lane_rd_addr = cmd_ff.end_pos;
         BK_CREATE: begin
            wr_go        = (sweep_ff != '0);
            wr_lane      = count_ff[EW-1:0];
            lane_wr_data = (sweep_prev < cmd_ff.end_pos) ? inc_rd_data : 8'h00;
         end
         BK_COPY: wr_go = (sweep_ff != '0);
         default: ;
      endcase
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         lane_wr_en[i] = wr_go && (wr_lane == EW'(i));
      end
   end

   // datapath next values
   always_comb begin
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      flags_in      = flags_ff;
      hit_idx_in    = hit_idx_ff;
      sweep_in      = sweep_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_in = head;
            end
         end
         BK_CHAR_CMP: begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
               flags_in[i] = flags_ff[i] && (lane_rd_data[i] == cmd_ff.ch);
            end
         end
         BK_FIND_CMP: begin
            hit_idx_in = hit_idx;
            sweep_in   = '0;
            if (cmd_ff.mode == MODE_NONE) begin
               flags_in = '1;
            end else if (cmd_ff.too_long) begin
               status_in = ST_TOOLONG;
            end else begin
               unique case (cmd_ff.mode)
                  MODE_CREATE: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else if (hit_any) begin
                        status_in = ST_EXISTS;
                     end else begin
                        status_in = ST_CREATED;
                     end
                  end
                  MODE_DELETE: begin
                     status_in = hit_any ? ST_DELETED : ST_NOTFOUND;
                     // deleting the last entry needs no copy
                     if (hit_any && hit_idx == last_idx) begin
                        count_in = count_dec;
                     end
                  end
                  default: status_in = hit_any ? ST_FOUND : ST_NOTFOUND;
               endcase
            end
         end
         BK_CREATE: begin
            sweep_in = sweep_ff + SW'(1);
            if (sweep_done) begin
               count_in = count_ff + CW'(1);
            end
         end
         BK_COPY: begin
            sweep_in = sweep_ff + SW'(1);
            if (sweep_done) begin
               count_in = count_dec;
            end
         end
         BK_RESULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               flags_in      = '1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         flags_ff     <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      hit_idx_ff    <= hit_idx_in;
      sweep_ff      <= sweep_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// ===== hw/rtl/name_table_insert_delete_search.sv =====
`timescale 1ns / 1ps

// Name table: holds up to MAX_ENTRIES unique names of at most NAME_BYTES-1
// characters each, starting empty. A name comes in one character per
// transaction with the operation in req_tuser and req_tlast on the final
// character; zero characters are dropped. On the final character the table is
// created into, deleted from (last entry moved into the freed slot) or
// searched, and one result transaction returns the status and the entry count;
// mode three only clears the name being received and returns nothing.
// The front end takes one transaction per cycle while its four-deep command
// queue has room. The back end takes each character from the queue, reads all
// entries at that position and compares; on the final character it adds a
// lookup at the name's end, a byte sweep for a create or for a delete that
// moves an entry, and a result state that waits for the output. The sweep
// through the per-entry byte memories sets the cost of create and delete.

module name_table_insert_delete_search import ntid_pkg::*; #(
   parameter int MAX_ENTRIES = 16,
   parameter int NAME_BYTES = 32,
   localparam int CW = $clog2(MAX_ENTRIES + 1),
   localparam int RSP_W = ((3 + CW + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // name_char
   input  logic [1:0]       req_tuser,   // mode
   input  logic             req_tlast,   // name_last
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // status, entry_count, zero fill
);

   localparam int PW      = $clog2(NAME_BYTES);
   localparam int CMD_W   = 2 * PW + 13;
   localparam int Q_DEPTH = 4;

   logic             q_push;
   logic [CMD_W-1:0] q_data;
   logic             q_full;
   logic             q_pop;
   logic             q_not_empty;
   logic [CMD_W-1:0] q_head;
   status_type       rsp_status;
   logic [CW-1:0]    rsp_count;

   // front end: position tracking and too-long detection per name
   ntid_front #(
      .NAME_BYTES (NAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .name_char  (req_tdata),
      .req_mode   (req_tuser),
      .name_last  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_data)
   );

   // command queue between the two halves
   ntid_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // back end: entry matching, table updates and result register
   ntid_back #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .NAME_BYTES  (NAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_not_empty),
      .cmd_head   (q_head),
      .cmd_pop    (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   // pack result: status in the low bits, count above it
   assign rsp_tdata = RSP_W'({rsp_count, rsp_status});

   // a full table reports exactly the maximum count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_FULL) |-> (rsp_count == CW'(MAX_ENTRIES)))
      else $error("table full reported below capacity");

   // a successful create leaves at least one entry
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_CREATED) |-> (rsp_count != '0))
      else $error("create reported with empty table");

   // a successful delete leaves the table below capacity
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_status == ST_DELETED) |-> (rsp_count != CW'(MAX_ENTRIES)))
      else $error("delete reported with full table");

   // the entry count never goes past the capacity
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_count <= CW'(MAX_ENTRIES)))
      else $error("entry count beyond capacity");

endmodule

// ===== dv/tb_name_table_insert_delete_search.sv =====
`timescale 1ns / 1ps

module tb_name_table_insert_delete_search;
   import ntid_pkg::*;

   localparam int MAX_ENTRIES   = 16;
   localparam int NAME_BYTES    = 32;
   localparam int CW            = $clog2(MAX_ENTRIES + 1);
   localparam int RSP_W         = ((3 + CW + 7) / 8) * 8;
   localparam int ITEM_TARGET   = 1450;
   localparam int TAIL_ITEMS    = 150;
   localparam int POOL_SIZE     = 24;
   localparam int POOL_MAX      = 40;
   localparam int OPS_PER_PHASE = 40;
   localparam int SETTLE_CYCLES = 200;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_REPORTS   = 40;
   localparam int LONG_HOLD     = 400;

   typedef struct {
      mode_type   mode;
      logic [7:0] ch;
      logic       last;
      bit         drain;   // wait for every reply before this character goes out
   } char_item_type;

   typedef struct {
      status_type      status;
      logic [CW-1:0]   count;
   } reply_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = 8'h00;
   logic [1:0]       req_tuser  = MODE_CREATE;
   logic             req_tlast  = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   name_table_insert_delete_search uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // directory image kept alongside the block
   logic [7:0]             dir_bytes [MAX_ENTRIES][NAME_BYTES];
   int                     dir_count;
   logic [7:0]             name_buf [NAME_BYTES];
   int                     name_len;
   logic [MAX_ENTRIES-1:0] match_mask;
   bit                     overlong;

   char_item_type pending [$];
   reply_type     expected_replies [$];
   logic [7:0]    name_chars [$];
   logic [7:0]    alphabet [4];
   logic [7:0]    pool_chars [POOL_SIZE][POOL_MAX];
   int            pool_len [POOL_SIZE];

   int  results_predicted = 0;
   int  results_seen      = 0;
   int  chars_accepted    = 0;
   int  errors            = 0;
   int  reports           = 0;
   int  cycle_count       = 0;
   int  gap_left          = 0;
   int  stall_left        = 0;
   int  hold_left         = 0;
   bit  hold_done         = 1'b0;
   bit  tail_phase        = 1'b0;
   int  status_tally [7];
   char_item_type next_item;

   wire calm_send = ((chars_accepted / 128) % 4 == 3);
   wire calm_recv = ((results_seen / 48) % 3 == 2);

   // advance the directory image by one character, queue the reply if one is due
   function automatic bit dir_apply_char(input logic [1:0] op, input logic [7:0] ch,
                                         input logic last);
      int        i;
      int        j;
      int        hit;
      int        tail_idx;
      reply_type r;
      bit        produced;
      produced = 1'b0;
      if (ch != 8'h00) begin
         if (name_len >= NAME_BYTES - 1) begin
            overlong = 1'b1;
         end else begin
            name_buf[name_len] = ch;
            for (i = 0; i < MAX_ENTRIES; i++)
               if (dir_bytes[i][name_len] != ch) match_mask[i] = 1'b0;
            name_len++;
         end
      end
      if (last) begin
         if (op != MODE_NONE) begin
            hit = -1;
            for (i = dir_count - 1; i >= 0; i--)
               if (match_mask[i] && dir_bytes[i][name_len] == 8'h00) hit = i;
            if (overlong) begin
               r.status = ST_TOOLONG;
            end else if (op == MODE_CREATE) begin
               if (dir_count >= MAX_ENTRIES) begin
                  r.status = ST_FULL;
               end else if (hit >= 0) begin
                  r.status = ST_EXISTS;
               end else begin
                  for (j = 0; j < NAME_BYTES; j++)
                     dir_bytes[dir_count][j] = (j < name_len) ? name_buf[j] : 8'h00;
                  dir_count++;
                  r.status = ST_CREATED;
               end
            end else if (op == MODE_DELETE) begin
               if (hit < 0) begin
                  r.status = ST_NOTFOUND;
               end else begin
                  // last entry fills the hole
                  tail_idx = dir_count - 1;
                  for (j = 0; j < NAME_BYTES; j++)
                     dir_bytes[hit][j] = dir_bytes[tail_idx][j];
                  dir_count = tail_idx;
                  r.status = ST_DELETED;
               end
            end else begin
               r.status = (hit >= 0) ? ST_FOUND : ST_NOTFOUND;
            end
            r.count = dir_count[CW-1:0];
            expected_replies.push_back(r);
            produced = 1'b1;
         end
         name_len   = 0;
         overlong   = 1'b0;
         match_mask = '1;
      end
      return produced;
   endfunction

   // queue the characters in name_chars as one name; scramble varies mode before the end
   task automatic push_name(input mode_type op, input bit drain, input bit scramble);
      int            j;
      char_item_type it;
      for (j = 0; j < name_chars.size(); j++) begin
         it.ch    = name_chars[j];
         it.last  = (j == name_chars.size() - 1);
         it.mode  = (it.last || !scramble) ? op : mode_type'($urandom_range(0, 3));
         it.drain = drain && (j == 0);
         pending.push_back(it);
      end
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // sender: one character transaction per handshake
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (dir_apply_char(req_tuser, req_tdata, req_tlast))
               results_predicted <= results_predicted + 1;
            chars_accepted <= chars_accepted + 1;
         end
         tail_phase <= (pending.size() < TAIL_ITEMS);
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending.size() == 0 ||
                         (pending[0].drain &&
                          (req_tvalid || results_predicted != results_seen))) begin
               req_tvalid <= 1'b0;
            end else begin
               next_item = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_item.ch;
               req_tuser  <= next_item.mode;
               req_tlast  <= next_item.last;
               if (!tail_phase && !calm_send && $urandom_range(0, 3) == 0)
                  gap_left <= $urandom_range(1, 9);
            end
         end
      end
   end

   // receiver: one long hold-off to back the block up, then short random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_done && results_seen >= 40) begin
         hold_done  <= 1'b1;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!tail_phase && !calm_recv && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // reply checker
   always @(posedge clock) begin
      reply_type      want;
      logic [2:0]     got_status;
      logic [CW-1:0]  got_count;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen <= results_seen + 1;
         got_status = rsp_tdata[2:0];
         got_count  = rsp_tdata[3 +: CW];
         if (got_status < 7) status_tally[got_status]++;
         if (expected_replies.size() == 0) begin
            errors++;
            reports++;
            if (reports <= MAX_REPORTS)
               $display("%0t: reply with none due, expected nothing, got status %0d count %0d",
                        $time, got_status, got_count);
         end else begin
            want = expected_replies.pop_front();
            if (got_status != want.status) begin
               errors++;
               reports++;
               if (reports <= MAX_REPORTS)
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, got_status);
            end
            if (got_count != want.count) begin
               errors++;
               reports++;
               if (reports <= MAX_REPORTS)
                  $display("%0t: entry count mismatch, expected %0d, got %0d",
                           $time, want.count, got_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d characters left, %0d replies due", $time,
                  pending.size(), results_predicted - results_seen);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int       n;
      int       j;
      int       k;
      int       len;
      int       idx;
      int       roll;
      int       kind;
      int       phase;
      int       create_cut [3];
      int       delete_cut [3];
      mode_type op;

      for (k = 0; k < MAX_ENTRIES; k++)
         for (j = 0; j < NAME_BYTES; j++)
            dir_bytes[k][j] = 8'h00;
      for (j = 0; j < NAME_BYTES; j++) name_buf[j] = 8'h00;
      for (k = 0; k < 7; k++) status_tally[k] = 0;
      dir_count  = 0;
      name_len   = 0;
      overlong   = 1'b0;
      match_mask = '1;

      // directed: empty name, extreme characters, dropped zeros, moved entry on delete
      name_chars = '{8'h00};             push_name(MODE_CREATE, 1'b0, 1'b0);
      name_chars = '{8'h00};             push_name(MODE_SEARCH, 1'b0, 1'b0);
      name_chars = '{8'h01};             push_name(MODE_CREATE, 1'b0, 1'b0);
      name_chars = '{8'hff, 8'h00, 8'h80}; push_name(MODE_CREATE, 1'b0, 1'b1);
      name_chars = '{8'hff, 8'h80};      push_name(MODE_SEARCH, 1'b0, 1'b0);
      name_chars = '{8'hff, 8'h80};      push_name(MODE_CREATE, 1'b0, 1'b0);
      name_chars = '{8'h01};             push_name(MODE_DELETE, 1'b0, 1'b0);
      name_chars = '{8'hff, 8'h80};      push_name(MODE_SEARCH, 1'b0, 1'b1);
      name_chars = '{8'h01};             push_name(MODE_DELETE, 1'b0, 1'b0);
      name_chars = '{8'h7f};             push_name(MODE_NONE, 1'b0, 1'b0);
      name_chars = '{8'h00};             push_name(MODE_DELETE, 1'b0, 1'b0);
      name_chars = '{8'h55, 8'haa};      push_name(MODE_SEARCH, 1'b0, 1'b0);
      name_chars = '{8'hff};             push_name(MODE_SEARCH, 1'b0, 1'b0);
      name_chars = '{8'hff, 8'h80, 8'h00}; push_name(MODE_CREATE, 1'b0, 1'b0);

      // random phases over a small name pool: fill, mixed, drain
      create_cut = '{70, 45, 25};
      delete_cut = '{80, 70, 70};
      phase = 0;
      while (pending.size() < ITEM_TARGET) begin
         kind = phase % 3;
         for (k = 0; k < 4; k++) alphabet[k] = 8'($urandom_range(1, 255));
         for (k = 0; k < POOL_SIZE; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3)       len = 0;
            else if (roll < 73) len = $urandom_range(1, 4);
            else if (roll < 88) len = $urandom_range(5, 30);
            else if (roll < 94) len = NAME_BYTES - 1;
            else if (roll < 97) len = NAME_BYTES;
            else                len = $urandom_range(NAME_BYTES + 1, POOL_MAX);
            pool_len[k] = len;
            for (j = 0; j < len; j++)
               pool_chars[k][j] = ($urandom_range(0, 3) != 0) ?
                                  alphabet[$urandom_range(0, 3)] : 8'($urandom_range(1, 255));
         end
         for (n = 0; n < OPS_PER_PHASE && pending.size() < ITEM_TARGET; n++) begin
            roll = $urandom_range(0, 99);
            name_chars.delete();
            if (roll < 8) begin
               // junk: random characters, zeros included, any mode
               len = $urandom_range(0, 6);
               for (j = 0; j <= len; j++) name_chars.push_back(8'($urandom_range(0, 255)));
               op = mode_type'($urandom_range(0, 3));
            end else begin
               idx = $urandom_range(0, POOL_SIZE - 1);
               for (j = 0; j < pool_len[idx]; j++) begin
                  if ($urandom_range(0, 19) == 0) name_chars.push_back(8'h00);
                  name_chars.push_back(pool_chars[idx][j]);
               end
               if (name_chars.size() == 0 || $urandom_range(0, 29) == 0)
                  name_chars.push_back(8'h00);
               if (roll < create_cut[kind])      op = MODE_CREATE;
               else if (roll < delete_cut[kind]) op = MODE_DELETE;
               else if (roll < 97)               op = MODE_SEARCH;
               else                              op = MODE_NONE;
            end
            push_name(op, (n == 0) && (phase == 0 || $urandom_range(0, 2) == 0),
                      $urandom_range(0, 9) < 3);
         end
         phase++;
      end

      wait (!reset);
      @(posedge clock);
      while (pending.size() != 0 || req_tvalid || results_predicted != results_seen)
         @(posedge clock);
      // trailing characters without a reply may still be in the block
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (expected_replies.size() != 0) begin
         errors++;
         $display("%0t: %0d replies expected, none arrived", $time, expected_replies.size());
      end

      $display("covered %0d character transactions and %0d replies over %0d name pools",
               chars_accepted, results_seen, phase);
      $display("replies: created %0d, full %0d, exists %0d, deleted %0d,",
               status_tally[0], status_tally[1], status_tally[2], status_tally[3]);
      $display("         not found %0d, found %0d, too long %0d",
               status_tally[4], status_tally[5], status_tally[6]);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
